[design/lcar_pkg.sv]
// lcar_pkg: shared types, widths, register indexes and reset values for the
// load cell reader with tare. No dependencies; used by every design file.
`default_nettype none

package lcar_pkg;

    // converter word and result widths
    localparam int DATA_BITS  = 24;
    localparam int RAW_W      = 24;
    localparam int WEIGHT_W   = 32;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 8;
    localparam int WAIT_W     = 24;
    localparam int BIT_W      = $clog2(DATA_BITS + 2);
    localparam int MUL_CNT_W  = $clog2(RAW_W);
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int WEIGHT_LSB = 16;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 4;
    localparam int M_PAD_W   = M_TDATA_W - (1 + 3 * RAW_W + WEIGHT_W);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd3;

    localparam logic [WAIT_W-1:0] TIMEOUT_RST = 24'd100000;
    localparam logic [CNT_W-1:0]  COUNT_RST   = 8'd10;
    localparam logic [WAIT_W-1:0] GAP_RST     = 24'd10000;
    localparam logic [RAW_W-1:0]  SCALE_RST   = 24'd38955;

    // top bit flip that turns two's complement into offset binary
    localparam logic [RAW_W-1:0] SIGN_FLIP = RAW_W'(1) << (DATA_BITS - 1);

    // command codes
    localparam logic [S_TUSER_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [S_TUSER_W-1:0] CMD_WEIGH = 2'd1;
    localparam logic [S_TUSER_W-1:0] CMD_TARE  = 2'd2;

    // tick-level phase of the converter protocol
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_W,
        PH_SHIFT_W,
        PH_WAIT_T,
        PH_SHIFT_T,
        PH_GAP
    } phase_t;

    // clock-level sequencer around one word
    typedef enum logic [1:0] {
        ENG_IN,
        ENG_MUL,
        ENG_DIV,
        ENG_OUT
    } eng_t;

    // completion and value from a serial arithmetic unit
    typedef struct packed {
        logic                done;
        logic [SUM_W-1:0]    value;
    } unit_res_t;

endpackage

`default_nettype wire

[design/load_cell_adc_reader_tare.sv]
// load_cell_adc_reader_tare: top level of the load cell reader with tare,
// tick protocol sequencer and output register. Depends on lcar_pkg,
// lcar_mul and lcar_div.
//
//   channel  direction  word contents
//   s_       in         one timebase tick: command and sampled data line
//   m_       out        one status word per tick: clock level, flags, values
//   cfg_     in         register write, index and data
//
// A plain tick takes the word and then loads the output. A completed weight
// read first runs the bit-serial multiplier, and a completed tare with valid
// samples first runs the serial divider, before the output is loaded.
// Reset is synchronous and active low; the block comes out of reset ready.
// A stalled output word holds the block in its output state once the next
// word is ready; no further tick is taken until the stalled word has gone.
`default_nettype none

module load_cell_adc_reader_tare (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: data_line [0], zero padding [7:1]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lcar_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: cmd [1:0]
    input  wire logic [lcar_pkg::S_TUSER_W-1:0]  s_tuser,
    // m_tdata: clock_line [0], raw_reading [24:1], net_count [48:25],
    // weight_fixed [80:49], zero_offset [104:81], zero padding [111:105]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lcar_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: busy_res [0], weight_done [1], tare_done [2], reading_valid [3]
    output logic [lcar_pkg::M_TUSER_W-1:0]       m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lcar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcar_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [lcar_pkg::WAIT_W-1:0] timeout_reg;
    logic [lcar_pkg::CNT_W-1:0]  count_reg;
    logic [lcar_pkg::WAIT_W-1:0] gap_reg;
    logic [lcar_pkg::RAW_W-1:0]  scale_reg;

    // tick state
    lcar_pkg::phase_t            phase_reg, phase_next;
    logic [lcar_pkg::BIT_W-1:0]  bit_reg, bit_next, bit_inc;
    logic                        clk_reg, clk_next;
    logic [lcar_pkg::RAW_W-1:0]  shift_reg, shift_next;
    logic [lcar_pkg::WAIT_W-1:0] wait_reg, wait_next, wait_inc;
    logic [lcar_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [lcar_pkg::CNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [lcar_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    logic [lcar_pkg::RAW_W-1:0]  raw_reg, raw_next;
    logic [lcar_pkg::RAW_W-1:0]  net_reg, net_next;
    logic [lcar_pkg::WEIGHT_W-1:0] weight_reg;
    logic [lcar_pkg::RAW_W-1:0]  offset_reg;
    logic                        wdone_reg, wdone_next;
    logic                        tdone_reg, tdone_next;

    // reading completion and tare bookkeeping
    logic                        rd_fire, rd_tare, proceed;
    logic [lcar_pkg::RAW_W-1:0]  rd_val;
    logic [lcar_pkg::CNT_W-1:0]  n_samples;
    logic                        mul_go, div_go;
    logic                        data_line;
    logic [lcar_pkg::S_TUSER_W-1:0] cmd;

    // sequencer and output register
    lcar_pkg::eng_t              eng_reg, eng_next;
    logic                        take, out_load;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [lcar_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [lcar_pkg::M_TUSER_W-1:0] m_tuser_reg;
    lcar_pkg::unit_res_t         mul_res, div_res;

    assign data_line = s_tdata[0];
    assign cmd       = s_tuser;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= lcar_pkg::TIMEOUT_RST;
            count_reg   <= lcar_pkg::COUNT_RST;
            gap_reg     <= lcar_pkg::GAP_RST;
            scale_reg   <= lcar_pkg::SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lcar_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                lcar_pkg::REG_COUNT:   count_reg   <= cfg_data[lcar_pkg::CNT_W-1:0];
                lcar_pkg::REG_GAP:     gap_reg     <= cfg_data;
                lcar_pkg::REG_SCALE:   scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // tick update: converter protocol, reading completion, tare progress
    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        clk_next   = clk_reg;
        shift_next = shift_reg;
        wait_next  = wait_reg;
        sum_next   = sum_reg;
        vcnt_next  = vcnt_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        raw_next   = raw_reg;
        net_next   = net_reg;
        wdone_next = 1'b0;
        tdone_next = 1'b0;
        rd_fire    = 1'b0;
        rd_tare    = 1'b0;
        rd_val     = '0;
        proceed    = 1'b0;
        mul_go     = 1'b0;
        div_go     = 1'b0;
        wait_inc   = wait_reg + 1'b1;
        bit_inc    = bit_reg + 1'b1;
        n_samples  = (count_reg == '0) ? lcar_pkg::CNT_W'(1) : count_reg;

        case (phase_reg)
            lcar_pkg::PH_IDLE: begin
                if (cmd == lcar_pkg::CMD_WEIGH) begin
                    phase_next = lcar_pkg::PH_WAIT_W;
                    wait_next  = '0;
                end else if (cmd == lcar_pkg::CMD_TARE) begin
                    sum_next   = '0;
                    vcnt_next  = '0;
                    idx_next   = '0;
                    phase_next = lcar_pkg::PH_WAIT_T;
                    wait_next  = '0;
                end
            end
            lcar_pkg::PH_WAIT_W, lcar_pkg::PH_WAIT_T: begin
                rd_tare = (phase_reg == lcar_pkg::PH_WAIT_T);
                if (!data_line) begin
                    phase_next = rd_tare ? lcar_pkg::PH_SHIFT_T : lcar_pkg::PH_SHIFT_W;
                    bit_next   = '0;
                    clk_next   = 1'b0;
                    shift_next = '0;
                end else begin
                    wait_next = wait_inc;
                    if (wait_inc >= timeout_reg) begin
                        rd_fire = 1'b1;
                    end
                end
            end
            lcar_pkg::PH_SHIFT_W, lcar_pkg::PH_SHIFT_T: begin
                rd_tare = (phase_reg == lcar_pkg::PH_SHIFT_T);
                if (!clk_reg) begin
                    clk_next = 1'b1;
                end else begin
                    clk_next = 1'b0;
                    if (bit_reg < lcar_pkg::BIT_W'(lcar_pkg::DATA_BITS)) begin
                        shift_next = {shift_reg[lcar_pkg::RAW_W-2:0], data_line};
                    end
                    bit_next = bit_inc;
                    if (bit_inc >= lcar_pkg::BIT_W'(lcar_pkg::DATA_BITS + 1)) begin
                        bit_next = '0;
                        rd_fire  = 1'b1;
                        rd_val   = shift_next ^ lcar_pkg::SIGN_FLIP;
                    end
                end
            end
            lcar_pkg::PH_GAP: begin
                wait_next = wait_inc;
                if (wait_inc >= gap_reg) begin
                    proceed = 1'b1;
                end
            end
            default: begin
                phase_next = lcar_pkg::PH_IDLE;
            end
        endcase

        // a reading has finished, either timed out (zero) or clocked in
        if (rd_fire) begin
            raw_next   = rd_val;
            valid_next = |rd_val;
            if (!rd_tare) begin
                net_next   = (rd_val > offset_reg) ? rd_val - offset_reg : '0;
                phase_next = lcar_pkg::PH_IDLE;
                wdone_next = 1'b1;
                mul_go     = 1'b1;
            end else begin
                if (|rd_val) begin
                    sum_next = sum_reg + lcar_pkg::SUM_W'(rd_val);
                    if (vcnt_reg != '1) begin
                        vcnt_next = vcnt_reg + 1'b1;
                    end
                end
                if (idx_reg != '1) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (gap_reg == '0) begin
                    proceed = 1'b1;
                end else begin
                    phase_next = lcar_pkg::PH_GAP;
                    wait_next  = '0;
                end
            end
        end

        // next tare sample or the average
        if (proceed) begin
            if (idx_next >= n_samples) begin
                div_go     = (vcnt_next != '0);
                phase_next = lcar_pkg::PH_IDLE;
                tdone_next = 1'b1;
            end else begin
                phase_next = lcar_pkg::PH_WAIT_T;
                wait_next  = '0;
            end
        end
    end

    // sequencer: take a word, run a unit if needed, then load the output
    always_comb begin
        eng_next      = eng_reg;
        s_tready      = 1'b0;
        out_load      = 1'b0;
        take          = 1'b0;
        case (eng_reg)
            lcar_pkg::ENG_IN: begin
                s_tready = 1'b1;
                take     = s_tvalid;
                if (s_tvalid) begin
                    if (mul_go) begin
                        eng_next = lcar_pkg::ENG_MUL;
                    end else if (div_go) begin
                        eng_next = lcar_pkg::ENG_DIV;
                    end else begin
                        eng_next = lcar_pkg::ENG_OUT;
                    end
                end
            end
            lcar_pkg::ENG_MUL: begin
                if (mul_res.done) begin
                    eng_next = lcar_pkg::ENG_OUT;
                end
            end
            lcar_pkg::ENG_DIV: begin
                if (div_res.done) begin
                    eng_next = lcar_pkg::ENG_OUT;
                end
            end
            lcar_pkg::ENG_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    eng_next = lcar_pkg::ENG_IN;
                end
            end
            default: begin
                eng_next = lcar_pkg::ENG_IN;
            end
        endcase
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eng_reg      <= lcar_pkg::ENG_IN;
            m_tvalid_reg <= 1'b0;
            phase_reg    <= lcar_pkg::PH_IDLE;
            bit_reg      <= '0;
            clk_reg      <= 1'b0;
            shift_reg    <= '0;
            wait_reg     <= '0;
            sum_reg      <= '0;
            vcnt_reg     <= '0;
            idx_reg      <= '0;
            valid_reg    <= 1'b0;
            raw_reg      <= '0;
            net_reg      <= '0;
            weight_reg   <= '0;
            offset_reg   <= '0;
            wdone_reg    <= 1'b0;
            tdone_reg    <= 1'b0;
        end else begin
            eng_reg      <= eng_next;
            m_tvalid_reg <= m_tvalid_next;
            if (take) begin
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                clk_reg   <= clk_next;
                shift_reg <= shift_next;
                wait_reg  <= wait_next;
                sum_reg   <= sum_next;
                vcnt_reg  <= vcnt_next;
                idx_reg   <= idx_next;
                valid_reg <= valid_next;
                raw_reg   <= raw_next;
                net_reg   <= net_next;
                wdone_reg <= wdone_next;
                tdone_reg <= tdone_next;
            end
            if (mul_res.done) begin
                weight_reg <= mul_res.value;
            end
            if (div_res.done) begin
                offset_reg <= div_res.value[lcar_pkg::RAW_W-1:0];
            end
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{lcar_pkg::M_PAD_W{1'b0}}, offset_reg, weight_reg,
                            net_reg, raw_reg, clk_reg};
            m_tuser_reg <= {valid_reg, tdone_reg, wdone_reg,
                            (phase_reg != lcar_pkg::PH_IDLE)};
        end
    end

    // serial arithmetic units
    lcar_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (take && mul_go),
        .mcand   (net_next),
        .mplier  (scale_reg),
        .res     (mul_res)
    );

    lcar_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (take && div_go),
        .dividend (sum_next),
        .divisor  (vcnt_next),
        .res      (div_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[design/lcar_mul.sv]
// lcar_mul: bit-serial shift-add multiplier, one multiplier bit per cycle,
// returns bits [47:16] of the 24 by 24 product. Depends on lcar_pkg.
`default_nettype none

module lcar_mul (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [lcar_pkg::RAW_W-1:0]  mcand,
    input  wire logic [lcar_pkg::RAW_W-1:0]  mplier,
    output lcar_pkg::unit_res_t              res
);

    logic [lcar_pkg::RAW_W-1:0]     acc_reg, acc_next;
    logic [lcar_pkg::RAW_W-1:0]     b_reg, b_next;
    logic [lcar_pkg::RAW_W-1:0]     a_reg;
    logic [lcar_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [lcar_pkg::RAW_W:0]       sum;

    // one add of the multiplicand per cycle, then shift the pair right
    always_comb begin
        sum       = {1'b0, acc_reg} + (b_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            b_next   = mplier;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            acc_next = sum[lcar_pkg::RAW_W:1];
            b_next   = {sum[0], b_reg[lcar_pkg::RAW_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lcar_pkg::MUL_CNT_W'(lcar_pkg::RAW_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
        if (start) begin
            a_reg <= mcand;
        end
    end

    assign res.done  = done_reg;
    assign res.value = {acc_reg, b_reg[lcar_pkg::RAW_W-1:lcar_pkg::WEIGHT_LSB]};

endmodule

`default_nettype wire

[design/lcar_div.sv]
// lcar_div: restoring divider, one quotient bit per cycle, for the tare
// average of a 32-bit sum by an 8-bit count. Depends on lcar_pkg.
`default_nettype none

module lcar_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [lcar_pkg::SUM_W-1:0]  dividend,
    input  wire logic [lcar_pkg::CNT_W-1:0]  divisor,
    output lcar_pkg::unit_res_t              res
);

    logic [lcar_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [lcar_pkg::SUM_W-1:0]     q_reg, q_next;
    logic [lcar_pkg::CNT_W-1:0]     d_reg;
    logic [lcar_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [lcar_pkg::CNT_W:0]       trial;
    logic [lcar_pkg::CNT_W+1:0]     diff;

    // bring down the next dividend bit and try a subtract
    always_comb begin
        trial     = {rem_reg, q_reg[lcar_pkg::SUM_W-1]};
        diff      = {1'b0, trial} - {2'b00, d_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            q_next   = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (!diff[lcar_pkg::CNT_W+1]) begin
                rem_next = diff[lcar_pkg::CNT_W-1:0];
                q_next   = {q_reg[lcar_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[lcar_pkg::CNT_W-1:0];
                q_next   = {q_reg[lcar_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lcar_pkg::DIV_CNT_W'(lcar_pkg::SUM_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        if (start) begin
            d_reg <= divisor;
        end
    end

    assign res.done  = done_reg;
    assign res.value = q_reg;

endmodule

`default_nettype wire

[design/lcar_chk.sv]
// lcar_chk: port-level checks on the load cell reader output stream, bound
// to the top level. Depends on lcar_pkg.
`default_nettype none

module lcar_chk (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [lcar_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic [lcar_pkg::M_TUSER_W-1:0]  m_tuser
);

    // no output word straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    // a stalled word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // a weight read and a tare never finish on the same tick
    a_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("weight and tare done together");

    // a finished operation leaves the reader idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1] || m_tuser[2]) |-> !m_tuser[0])
        else $error("busy on a completion word");

    // the valid flag tracks a nonzero raw reading
    a_valid_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[3] == (m_tdata[24:1] != '0)))
        else $error("reading valid disagrees with raw reading");

endmodule

bind load_cell_adc_reader_tare lcar_chk u_lcar_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[dv/load_cell_adc_reader_tare_tb.sv]
// load_cell_adc_reader_tare_tb: self-checking bench for the load cell reader with tare.
// Drives ticks and register writes; checks every status word by tick predictor or typed row.
// Depends on lcar_pkg and load_cell_adc_reader_tare only.

module load_cell_adc_reader_tare_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // unused command code, ignored by the block
    localparam logic [lcar_pkg::S_TUSER_W-1:0] CMD_NONE = 2'd3;
    // cycles left for the multiplier or divider to finish after a word
    localparam int LAT_PAUSE   = 40;
    // cycles with no handshake or register write before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // one status word as seen on the result channel
    typedef struct packed {
        logic                              clock_lvl;
        logic                              busy;
        logic                              weigh_done;
        logic                              tare_done;
        logic                              valid;
        logic [lcar_pkg::RAW_W-1:0]        raw;
        logic [lcar_pkg::RAW_W-1:0]        net;
        logic [lcar_pkg::WEIGHT_W-1:0]     weight;
        logic [lcar_pkg::RAW_W-1:0]        offset;
    } status_t;

    // one row of the directed table: a register write or a tick word
    typedef struct {
        bit                                is_reg;
        logic [lcar_pkg::CFG_IDX_W-1:0]    idx;
        logic [lcar_pkg::CFG_DATA_W-1:0]   val;
        logic [lcar_pkg::S_TUSER_W-1:0]    cmd;
        logic                              dl;
        bit                                typed;
        status_t                           want;
    } dir_row_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [lcar_pkg::S_TDATA_W-1:0]        s_tdata;
    logic [lcar_pkg::S_TUSER_W-1:0]        s_tuser;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [lcar_pkg::M_TDATA_W-1:0]        m_tdata;
    logic [lcar_pkg::M_TUSER_W-1:0]        m_tuser;
    logic                                  cfg_wr_en;
    logic [lcar_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [lcar_pkg::CFG_DATA_W-1:0]       cfg_data;

    load_cell_adc_reader_tare dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers
    logic [lcar_pkg::WAIT_W-1:0] cf_timeout;
    logic [lcar_pkg::CNT_W-1:0]  cf_count;
    logic [lcar_pkg::WAIT_W-1:0] cf_gap;
    logic [lcar_pkg::RAW_W-1:0]  cf_scale;

    // predictor copy of the protocol state
    lcar_pkg::phase_t              st_phase;
    logic [5:0]                    st_bit;
    logic                          st_clk;
    logic [lcar_pkg::RAW_W-1:0]    st_shift;
    logic [lcar_pkg::WAIT_W-1:0]   st_wait;
    logic [39:0]                   st_sum;
    logic [lcar_pkg::CNT_W-1:0]    st_nvalid;
    logic [lcar_pkg::CNT_W-1:0]    st_ntaken;
    logic [lcar_pkg::RAW_W-1:0]    st_offset;
    logic                          st_valid;
    logic [lcar_pkg::RAW_W-1:0]    held_raw;
    logic [lcar_pkg::RAW_W-1:0]    held_net;
    logic [lcar_pkg::WEIGHT_W-1:0] held_weight;
    logic                          fl_wdone;
    logic                          fl_tdone;

    status_t status_due[$];
    dir_row_t plan[$];
    logic [lcar_pkg::RAW_W-1:0] word_in;
    bit calm;
    bit tare_ok;
    int n_errors;
    int n_checked;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // close a tare sample, or end the tare once enough samples are in
    function automatic void tare_advance();
        logic [8:0] need;
        need = (cf_count == '0) ? 9'd1 : {1'b0, cf_count};
        if ({1'b0, st_ntaken} >= need) begin
            if (st_nvalid != '0)
                st_offset = lcar_pkg::RAW_W'(st_sum / st_nvalid);
            st_phase = lcar_pkg::PH_IDLE;
            fl_tdone = 1'b1;
        end else begin
            st_phase = lcar_pkg::PH_WAIT_T;
            st_wait  = '0;
        end
    endfunction

    // a reading has come in, or timed out with r zero
    function automatic void finish_reading(logic [lcar_pkg::RAW_W-1:0] r, bit is_tare);
        logic [47:0] prod;
        held_raw = r;
        st_valid = (r != '0);
        if (!is_tare) begin
            if (r == '0 || r <= st_offset)
                held_net = '0;
            else
                held_net = r - st_offset;
            prod = 48'(held_net) * 48'(cf_scale);
            held_weight = prod[47:lcar_pkg::WEIGHT_LSB];
            st_phase = lcar_pkg::PH_IDLE;
            fl_wdone = 1'b1;
        end else begin
            if (r != '0) begin
                st_sum = st_sum + 40'(r);
                if (st_nvalid < 8'd255)
                    st_nvalid = st_nvalid + 1'b1;
            end
            if (st_ntaken < 8'd255)
                st_ntaken = st_ntaken + 1'b1;
            if (cf_gap == '0) begin
                tare_advance();
            end else begin
                st_phase = lcar_pkg::PH_GAP;
                st_wait  = '0;
            end
        end
    endfunction

    // advance the protocol by one tick and return the status word it gives
    function automatic status_t predict_tick(logic [lcar_pkg::S_TUSER_W-1:0] cmd, logic dl);
        bit      is_tare;
        status_t s;
        fl_wdone = 1'b0;
        fl_tdone = 1'b0;
        case (st_phase)
            lcar_pkg::PH_IDLE: begin
                if (cmd == lcar_pkg::CMD_WEIGH) begin
                    st_phase = lcar_pkg::PH_WAIT_W;
                    st_wait  = '0;
                end else if (cmd == lcar_pkg::CMD_TARE) begin
                    st_sum    = '0;
                    st_nvalid = '0;
                    st_ntaken = '0;
                    st_phase  = lcar_pkg::PH_WAIT_T;
                    st_wait   = '0;
                end
            end
            lcar_pkg::PH_WAIT_W, lcar_pkg::PH_WAIT_T: begin
                is_tare = (st_phase == lcar_pkg::PH_WAIT_T);
                if (!dl) begin
                    if (is_tare)
                        st_phase = lcar_pkg::PH_SHIFT_T;
                    else
                        st_phase = lcar_pkg::PH_SHIFT_W;
                    st_bit   = '0;
                    st_clk   = 1'b0;
                    st_shift = '0;
                end else begin
                    st_wait = st_wait + 1'b1;
                    if (st_wait >= cf_timeout)
                        finish_reading('0, is_tare);
                end
            end
            lcar_pkg::PH_SHIFT_W, lcar_pkg::PH_SHIFT_T: begin
                is_tare = (st_phase == lcar_pkg::PH_SHIFT_T);
                if (!st_clk) begin
                    st_clk = 1'b1;
                end else begin
                    // falling half of a pulse: sample the data line
                    st_clk = 1'b0;
                    if (st_bit < lcar_pkg::DATA_BITS)
                        st_shift = {st_shift[lcar_pkg::RAW_W-2:0], dl};
                    st_bit = st_bit + 1'b1;
                    if (st_bit >= lcar_pkg::DATA_BITS + 1) begin
                        st_bit = '0;
                        finish_reading(st_shift ^ lcar_pkg::SIGN_FLIP, is_tare);
                    end
                end
            end
            lcar_pkg::PH_GAP: begin
                st_wait = st_wait + 1'b1;
                if (st_wait >= cf_gap)
                    tare_advance();
            end
            default: st_phase = lcar_pkg::PH_IDLE;
        endcase
        s.clock_lvl  = st_clk;
        s.busy       = (st_phase != lcar_pkg::PH_IDLE);
        s.weigh_done = fl_wdone;
        s.tare_done  = fl_tdone;
        s.valid      = st_valid;
        s.raw        = held_raw;
        s.net        = held_net;
        s.weight     = held_weight;
        s.offset     = st_offset;
        return s;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch at word %0d: %s got %h expected %h",
                 n_checked, what, got, want);
    endtask

    // compare each status word taken from the result channel with the oldest one due
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.clock_lvl  = m_tdata[0];
            got.raw        = m_tdata[24:1];
            got.net        = m_tdata[48:25];
            got.weight     = m_tdata[80:49];
            got.offset     = m_tdata[104:81];
            got.busy       = m_tuser[0];
            got.weigh_done = m_tuser[1];
            got.tare_done  = m_tuser[2];
            got.valid      = m_tuser[3];
            if (status_due.size() == 0) begin
                report("word with nothing due", m_tdata[31:0], '0);
            end else begin
                want = status_due.pop_front();
                if (got.clock_lvl !== want.clock_lvl)
                    report("clock_line", got.clock_lvl, want.clock_lvl);
                if (got.busy !== want.busy)
                    report("busy_res", got.busy, want.busy);
                if (got.weigh_done !== want.weigh_done)
                    report("weight_done", got.weigh_done, want.weigh_done);
                if (got.tare_done !== want.tare_done)
                    report("tare_done", got.tare_done, want.tare_done);
                if (got.valid !== want.valid)
                    report("reading_valid", got.valid, want.valid);
                if (got.raw !== want.raw)
                    report("raw_reading", got.raw, want.raw);
                if (got.net !== want.net)
                    report("net_count", got.net, want.net);
                if (got.weight !== want.weight)
                    report("weight_fixed", got.weight, want.weight);
                if (got.offset !== want.offset)
                    report("zero_offset", got.offset, want.offset);
            end
            n_checked++;
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = calm || ($urandom_range(0, 99) >= 21);
        end
    end

    // hang detection: any handshake or register write restarts the count
    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_run = 0;
            else
                idle_run++;
        end
        $display("FAIL load_cell_adc_reader_tare");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    // present one tick word, wait for it to be taken, then log its status word
    task automatic send_word(logic [lcar_pkg::S_TUSER_W-1:0] cmd, logic dl, bit typed,
                             status_t want);
        status_t s;
        while (!calm && $urandom_range(0, 99) < 21)
            @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = lcar_pkg::S_TDATA_W'(dl);
        s_tuser  = cmd;
        do @(posedge aclk); while (!s_tready);
        s = predict_tick(cmd, dl);
        status_due.push_back(typed ? want : s);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(logic [lcar_pkg::CFG_IDX_W-1:0] idx,
                             logic [lcar_pkg::CFG_DATA_W-1:0] val);
        while (status_due.size() != 0)
            @(posedge aclk);
        repeat (LAT_PAUSE) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        case (idx)
            lcar_pkg::REG_TIMEOUT: cf_timeout = val;
            lcar_pkg::REG_COUNT:   cf_count   = val[lcar_pkg::CNT_W-1:0];
            lcar_pkg::REG_GAP:     cf_gap     = val;
            lcar_pkg::REG_SCALE:   cf_scale   = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // choose the next tick word from the predicted phase; mostly well-formed reads
    task automatic pick_item(input bit drain, output logic [lcar_pkg::S_TUSER_W-1:0] cmd,
                             output logic dl);
        int pick;
        cmd = lcar_pkg::CMD_TICK;
        dl  = 1'($urandom_range(0, 1));
        if (!drain && $urandom_range(0, 99) < 8) begin
            // noise: any code and level in any phase
            cmd = lcar_pkg::S_TUSER_W'($urandom_range(0, 3));
        end else begin
            case (st_phase)
                lcar_pkg::PH_IDLE: begin
                    pick = $urandom_range(0, 9);
                    if (drain)
                        cmd = lcar_pkg::CMD_TICK;
                    else if (pick < 5)
                        cmd = lcar_pkg::CMD_WEIGH;
                    else if (pick < 8)
                        cmd = lcar_pkg::CMD_TARE;
                    else if (pick == 8)
                        cmd = CMD_NONE;
                end
                lcar_pkg::PH_WAIT_W, lcar_pkg::PH_WAIT_T: begin
                    dl = (drain || $urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
                    if (!dl) begin
                        // pick the converter word for the coming read
                        pick = $urandom_range(0, 9);
                        case (pick)
                            0: word_in = lcar_pkg::SIGN_FLIP;     // reads back as zero
                            1: word_in = '0;
                            2: word_in = '1;
                            3: word_in = ~lcar_pkg::SIGN_FLIP;    // largest reading
                            4, 5: word_in = (st_offset ^ lcar_pkg::SIGN_FLIP)
                                            + lcar_pkg::RAW_W'($urandom_range(0, 6))
                                            - lcar_pkg::RAW_W'(3);
                            default: word_in = lcar_pkg::RAW_W'($urandom);
                        endcase
                    end
                end
                lcar_pkg::PH_SHIFT_W, lcar_pkg::PH_SHIFT_T: begin
                    if (st_clk && st_bit < lcar_pkg::DATA_BITS)
                        dl = word_in[lcar_pkg::DATA_BITS - 1 - int'(st_bit)];
                end
                default: ;
            endcase
        end
        // tares are kept out of settings where one would run for ages
        if (!tare_ok && st_phase == lcar_pkg::PH_IDLE && cmd == lcar_pkg::CMD_TARE)
            cmd = CMD_NONE;
    endtask

    // bring the protocol back to idle, then set all four registers and run random words
    task automatic run_phase(logic [lcar_pkg::CFG_DATA_W-1:0] timeout,
                             logic [lcar_pkg::CFG_DATA_W-1:0] count,
                             logic [lcar_pkg::CFG_DATA_W-1:0] gap,
                             logic [lcar_pkg::CFG_DATA_W-1:0] scale,
                             bit allow_tare, int n_words);
        logic [lcar_pkg::S_TUSER_W-1:0] cmd;
        logic dl;
        while (st_phase != lcar_pkg::PH_IDLE) begin
            pick_item(1'b1, cmd, dl);
            send_word(cmd, dl, 1'b0, '0);
        end
        write_reg(lcar_pkg::REG_TIMEOUT, timeout);
        write_reg(lcar_pkg::REG_COUNT, count);
        write_reg(lcar_pkg::REG_GAP, gap);
        write_reg(lcar_pkg::REG_SCALE, scale);
        tare_ok = allow_tare;
        repeat (n_words) begin
            // now and then hold off until every status word is back
            if ($urandom_range(0, 199) == 0) begin
                while (status_due.size() != 0)
                    @(posedge aclk);
                @(negedge aclk);
            end
            pick_item(1'b0, cmd, dl);
            send_word(cmd, dl, 1'b0, '0);
        end
    endtask

    function automatic dir_row_t mk_reg(logic [lcar_pkg::CFG_IDX_W-1:0] idx,
                                        logic [lcar_pkg::CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '{default: '0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    // tick row; when typed, the status word is idle-like with only these flags set
    function automatic dir_row_t mk_tick(logic [lcar_pkg::S_TUSER_W-1:0] cmd, logic dl,
                                         bit typed, logic busy, logic wdone, logic tdone);
        dir_row_t r;
        r = '{default: '0};
        r.cmd = cmd;
        r.dl  = dl;
        r.typed = typed;
        r.want = '0;
        r.want.busy       = busy;
        r.want.weigh_done = wdone;
        r.want.tare_done  = tdone;
        return r;
    endfunction

    // ---------------------------------------------------------------- main sequence
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = lcar_pkg::CMD_TICK;
        cfg_wr_en = 1'b0;
        cfg_index = lcar_pkg::REG_TIMEOUT;
        cfg_data  = '0;
        calm      = 1'b0;
        tare_ok   = 1'b1;
        n_errors  = 0;
        n_checked = 0;
        word_in   = '0;

        cf_timeout = lcar_pkg::TIMEOUT_RST;
        cf_count   = lcar_pkg::COUNT_RST;
        cf_gap     = lcar_pkg::GAP_RST;
        cf_scale   = lcar_pkg::SCALE_RST;
        st_phase   = lcar_pkg::PH_IDLE;
        st_bit     = '0;
        st_clk     = 1'b0;
        st_shift   = '0;
        st_wait    = '0;
        st_sum     = '0;
        st_nvalid  = '0;
        st_ntaken  = '0;
        st_offset  = '0;
        st_valid   = 1'b0;
        held_raw   = '0;
        held_net   = '0;
        held_weight = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: idle words, ignored codes, timeouts and the tare corner cases
        plan.push_back(mk_reg(lcar_pkg::REG_TIMEOUT, 24'd1));
        plan.push_back(mk_tick(lcar_pkg::CMD_TICK,  1'b1, 1, 0, 0, 0));
        plan.push_back(mk_tick(CMD_NONE,            1'b0, 1, 0, 0, 0));
        plan.push_back(mk_tick(lcar_pkg::CMD_WEIGH, 1'b1, 1, 1, 0, 0));
        plan.push_back(mk_tick(lcar_pkg::CMD_TICK,  1'b1, 1, 0, 1, 0));  // read times out
        plan.push_back(mk_reg(lcar_pkg::REG_TIMEOUT, 24'd0));
        plan.push_back(mk_tick(lcar_pkg::CMD_WEIGH, 1'b0, 1, 1, 0, 0));
        plan.push_back(mk_tick(lcar_pkg::CMD_TARE,  1'b1, 1, 0, 1, 0));  // busy: tare ignored
        plan.push_back(mk_reg(lcar_pkg::REG_COUNT, 24'd0));              // sample count of zero
        plan.push_back(mk_reg(lcar_pkg::REG_GAP, 24'd0));
        plan.push_back(mk_tick(lcar_pkg::CMD_TARE,  1'b1, 1, 1, 0, 0));
        plan.push_back(mk_tick(CMD_NONE,            1'b1, 1, 0, 0, 1));  // no valid sample
        plan.push_back(mk_reg(lcar_pkg::REG_TIMEOUT, 24'd2));
        plan.push_back(mk_reg(lcar_pkg::REG_GAP, 24'd1));
        plan.push_back(mk_tick(lcar_pkg::CMD_TARE,  1'b1, 1, 1, 0, 0));
        plan.push_back(mk_tick(lcar_pkg::CMD_TICK,  1'b1, 1, 1, 0, 0));
        plan.push_back(mk_tick(lcar_pkg::CMD_TICK,  1'b1, 1, 1, 0, 0));  // into the gap
        plan.push_back(mk_tick(lcar_pkg::CMD_WEIGH, 1'b0, 1, 0, 0, 1));  // gap ends the tare
        plan.push_back(mk_tick(lcar_pkg::CMD_WEIGH, 1'b0, 1, 1, 0, 0));
        plan.push_back(mk_tick(lcar_pkg::CMD_TICK,  1'b0, 0, 0, 0, 0));
        plan.push_back(mk_tick(lcar_pkg::CMD_TICK,  1'b1, 0, 0, 0, 0));
        foreach (plan[i]) begin
            if (plan[i].is_reg)
                write_reg(plan[i].idx, plan[i].val);
            else
                send_word(plan[i].cmd, plan[i].dl, plan[i].typed, plan[i].want);
        end

        // random: a spread of register settings, extremes included
        run_phase(24'd20, 24'd3, 24'd2, 24'd38955, 1'b1, 280);
        calm = 1'b1;
        run_phase(24'hFFFFFF, 24'd1, 24'd0, 24'hFFFFFF, 1'b1, 280);
        calm = 1'b0;
        run_phase(24'd1, 24'd2, 24'hFFFFFF, 24'd0, 1'b0, 280);
        run_phase(24'd4, 24'd255, 24'd1, 24'd1, 1'b0, 280);
        run_phase(24'd8, 24'd4, 24'd3,
                  lcar_pkg::CFG_DATA_W'($urandom_range(1000, 100000)), 1'b1, 280);
        run_phase(24'd100000, 24'd0, 24'd0, 24'd38955, 1'b1, 280);

        // drain and let the arithmetic units settle
        while (status_due.size() != 0)
            @(posedge aclk);
        repeat (LAT_PAUSE) @(posedge aclk);
        if (status_due.size() != 0)
            report("words never returned", status_due.size(), '0);

        if (n_errors == 0)
            $display("PASS load_cell_adc_reader_tare");
        else
            $display("FAIL load_cell_adc_reader_tare");
        $finish;
    end

endmodule

[sim.f]
design/lcar_pkg.sv
design/lcar_mul.sv
design/lcar_div.sv
design/load_cell_adc_reader_tare.sv
design/lcar_chk.sv
dv/load_cell_adc_reader_tare_tb.sv
